// ===== src/spr_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the shortest path relaxation engine
// used by every module under src; depends on nothing

package spr_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 256;
    localparam int WEIGHT_BITS  = 16;

    localparam int VID_W  = $clog2(MAX_VERTICES);
    localparam int VCNT_W = VID_W + 1;
    localparam int EIDX_W = $clog2(MAX_EDGES);
    localparam int ECNT_W = EIDX_W + 1;
    localparam int DIST_W = 32;

    localparam logic [DIST_W-1:0] UNREACHED_DIST = 32'h7f7f_7f7f;
    localparam logic [DIST_W-1:0] DIST_MAX       = 32'h7fff_ffff;
    localparam logic [DIST_W-1:0] DIST_MIN       = 32'h8000_0000;

    // command codes
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_SOLVE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // result status codes
    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_NEG_CYC = 2'd1;
    localparam logic [1:0] STS_DROPPED = 2'd2;

    // register index of vertex_count
    localparam logic REG_VERTEX_COUNT = 1'b0;

    typedef struct packed {
        logic [VID_W-1:0]       from;
        logic [VID_W-1:0]       to;
        logic [WEIGHT_BITS-1:0] weight;
    } t_edge;

    typedef struct packed {
        logic              en;
        logic [EIDX_W-1:0] addr;
        t_edge             data;
    } t_edge_wr;

    typedef struct packed {
        logic [DIST_W-1:0] path_dist;
        logic [VID_W-1:0]  parent;
    } t_vent;

    typedef struct packed {
        logic             en;
        logic [VID_W-1:0] addr;
        t_vent            data;
    } t_vent_wr;

endpackage

// ===== src/shortest_path_relaxation.sv =====
`timescale 1ns / 1ps
// top level of the shortest path relaxation engine (single source, negative weights)
// depends on spr_pkg, spr_edge_mem, spr_vertex_mem, spr_relax_unit
//
// usage:
//  - input stream: tuser carries the command (add edge, solve, clear edge list),
//    tdata the edge endpoints, weight and source vertex. add and clear may arrive
//    back to back; they produce no result
//  - a solve runs relaxation passes over the stored edges; each edge is read, then
//    its two vertex entries, then it goes through add and compare unless skipped;
//    a bookkeeping state ends each pass. at most vertex_count-1 passes and a check
//    pass; an unchanged pass ends early
//  - results: vertex_count transfers on the output stream, each read from the
//    vertex store first, tlast on the final vertex; or one transfer with
//    status negative cycle. tready stays low from solve accept until the last
//    result is loaded into the output register
//  - a stalled receiver holds the output register; the sequencer waits
//  - reset empties the edge list, clears the overflow flag, sets vertex_count
//    to 64 and drops any pending result; no clearing pass is needed
//  - the user writes vertex_count through the apb port while the block is idle (not enforced)

module shortest_path_relaxation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [5:0] edge_from, [11:6] edge_to, [27:12] edge_weight, [33:28] source_vertex
    input  logic [39:0] i_s_axis_tdata,
    // [1:0] command
    input  logic [1:0]  i_s_axis_tuser,
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [5:0] vertex, [37:6] path_distance, [38] reachable, [44:39] parent_vertex
    output logic [47:0] o_m_axis_tdata,
    // [1:0] status
    output logic [1:0]  o_m_axis_tuser,
    output logic        o_m_axis_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int VID_W  = spr_pkg::VID_W;
    localparam int VCNT_W = spr_pkg::VCNT_W;
    localparam int EIDX_W = spr_pkg::EIDX_W;
    localparam int ECNT_W = spr_pkg::ECNT_W;
    localparam int DIST_W = spr_pkg::DIST_W;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;
    localparam logic [3:0] S_EREAD = 4'd2;
    localparam logic [3:0] S_VREAD = 4'd3;
    localparam logic [3:0] S_ADD   = 4'd4;
    localparam logic [3:0] S_CMP   = 4'd5;
    localparam logic [3:0] S_PASS  = 4'd6;
    localparam logic [3:0] S_ORD   = 4'd7;
    localparam logic [3:0] S_OSEND = 4'd8;
    localparam logic [3:0] S_NEG   = 4'd9;

    logic [3:0]              r_state;
    logic [VCNT_W-1:0]       r_vc;
    logic [VCNT_W-1:0]       r_nv;
    logic [VID_W-1:0]        r_src;
    logic [ECNT_W-1:0]       r_eidx;
    logic [ECNT_W-1:0]       r_edge_total;
    logic                    r_overflow;
    logic [VCNT_W-1:0]       r_pass;
    logic                    r_check;
    logic                    r_changed;
    logic [spr_pkg::MAX_VERTICES-1:0] r_reached;
    logic [VID_W-1:0]        r_oidx;

    logic                    r_out_valid;
    logic [VID_W-1:0]        r_out_vertex;
    logic [DIST_W-1:0]       r_out_dist;
    logic                    r_out_reach;
    logic [VID_W-1:0]        r_out_parent;
    logic [1:0]              r_out_status;
    logic                    r_out_last;

    // input field views
    logic [1:0]              w_cmd;
    logic [VID_W-1:0]        w_in_from;
    logic [VID_W-1:0]        w_in_to;
    logic [15:0]             w_in_weight;
    logic [VID_W-1:0]        w_in_src;
    logic                    w_in_xfer;

    assign w_cmd       = i_s_axis_tuser;
    assign w_in_from   = i_s_axis_tdata[5:0];
    assign w_in_to     = i_s_axis_tdata[11:6];
    assign w_in_weight = i_s_axis_tdata[27:12];
    assign w_in_src    = i_s_axis_tdata[33:28];
    assign w_in_xfer   = i_s_axis_tvalid && o_s_axis_tready;

    assign o_s_axis_tready = (r_state == S_IDLE);

    // config port
    logic w_cfg_wr;
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == spr_pkg::REG_VERTEX_COUNT);
    assign prdata   = (paddr[2] == spr_pkg::REG_VERTEX_COUNT) ? {25'd0, r_vc} : 32'd0;

    // vertex count in range 1..64
    logic [VCNT_W-1:0] w_nv_clamp;
    always_comb begin
        if (r_vc == '0) begin
            w_nv_clamp = VCNT_W'(1);
        end else if (r_vc > VCNT_W'(spr_pkg::MAX_VERTICES)) begin
            w_nv_clamp = VCNT_W'(spr_pkg::MAX_VERTICES);
        end else begin
            w_nv_clamp = r_vc;
        end
    end

    // edge store
    spr_pkg::t_edge_wr w_edge_wr;
    spr_pkg::t_edge    w_edge;

    assign w_edge_wr.en          = w_in_xfer && (w_cmd == spr_pkg::CMD_ADD) &&
                                   !r_edge_total[ECNT_W-1];
    assign w_edge_wr.addr        = r_edge_total[EIDX_W-1:0];
    assign w_edge_wr.data.from   = w_in_from;
    assign w_edge_wr.data.to     = w_in_to;
    assign w_edge_wr.data.weight = w_in_weight;

    spr_edge_mem u_edge_mem (
        .i_clk     (i_clk),
        .i_wr      (w_edge_wr),
        .i_rd_addr (r_eidx[EIDX_W-1:0]),
        .o_rd_data (w_edge)
    );

    // vertex store: port a serves the edge tail or the output sweep, port b the head
    spr_pkg::t_vent_wr w_vwr;
    spr_pkg::t_vent    w_vent_a;
    spr_pkg::t_vent    w_vent_b;
    logic [VID_W-1:0]  w_addr_a;
    logic [DIST_W-1:0] w_sum;
    logic              w_better;

    logic w_out_phase;
    assign w_out_phase = (r_state == S_ORD) || (r_state == S_OSEND);
    assign w_addr_a    = w_out_phase ? r_oidx : w_edge.from;

    always_comb begin
        w_vwr = '0;
        if (r_state == S_INIT) begin
            w_vwr.en             = ({1'b0, r_src} < r_nv);
            w_vwr.addr           = r_src;
            w_vwr.data.path_dist = '0;
            w_vwr.data.parent    = r_src;
        end else if (r_state == S_CMP) begin
            w_vwr.en             = w_better && !r_check;
            w_vwr.addr           = w_edge.to;
            w_vwr.data.path_dist = w_sum;
            w_vwr.data.parent    = w_edge.from;
        end
    end

    spr_vertex_mem u_vertex_mem (
        .i_clk       (i_clk),
        .i_wr        (w_vwr),
        .i_rd_addr_a (w_addr_a),
        .i_rd_addr_b (w_edge.to),
        .o_rd_data_a (w_vent_a),
        .o_rd_data_b (w_vent_b)
    );

    spr_relax_unit u_relax (
        .i_clk       (i_clk),
        .i_dist_u    (w_vent_a.path_dist),
        .i_weight    (w_edge.weight),
        .i_dist_v    (w_vent_b.path_dist),
        .i_v_reached (r_reached[w_edge.to]),
        .o_sum       (w_sum),
        .o_better    (w_better)
    );

    // edge walk helpers
    logic w_skip;
    logic w_last_edge;
    logic w_out_free;
    logic w_out_last;

    assign w_skip      = ({1'b0, w_edge.from} >= r_nv) || ({1'b0, w_edge.to} >= r_nv) ||
                         !r_reached[w_edge.from];
    assign w_last_edge = ((r_eidx + ECNT_W'(1)) == r_edge_total);
    assign w_out_free  = !r_out_valid || i_m_axis_tready;
    assign w_out_last  = (({1'b0, r_oidx} + VCNT_W'(1)) == r_nv);

    // sequencer and edge list control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_vc         <= VCNT_W'(spr_pkg::MAX_VERTICES);
            r_edge_total <= '0;
            r_overflow   <= 1'b0;
            r_eidx       <= '0;
            r_pass       <= '0;
            r_check      <= 1'b0;
            r_changed    <= 1'b0;
            r_oidx       <= '0;
        end else begin
            if (w_cfg_wr) begin
                r_vc <= pwdata[VCNT_W-1:0];
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        unique case (w_cmd)
                            spr_pkg::CMD_ADD: begin
                                if (r_edge_total[ECNT_W-1]) begin
                                    r_overflow <= 1'b1;
                                end else begin
                                    r_edge_total <= r_edge_total + ECNT_W'(1);
                                end
                            end
                            spr_pkg::CMD_CLEAR: begin
                                r_edge_total <= '0;
                                r_overflow   <= 1'b0;
                            end
                            spr_pkg::CMD_SOLVE: begin
                                r_nv    <= w_nv_clamp;
                                r_src   <= w_in_src;
                                r_state <= S_INIT;
                            end
                            default: begin
                                // unused command, ignored
                            end
                        endcase
                    end
                end
                S_INIT: begin
                    r_pass    <= VCNT_W'(1);
                    r_check   <= (r_nv == VCNT_W'(1));
                    r_eidx    <= '0;
                    r_changed <= 1'b0;
                    r_state   <= (r_edge_total == '0) ? S_PASS : S_EREAD;
                end
                S_EREAD: begin
                    r_state <= S_VREAD;
                end
                S_VREAD: begin
                    if (w_skip) begin
                        r_eidx  <= r_eidx + ECNT_W'(1);
                        r_state <= w_last_edge ? S_PASS : S_EREAD;
                    end else begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (w_better && r_check) begin
                        r_state <= S_NEG;
                    end else begin
                        if (w_better) begin
                            r_changed <= 1'b1;
                        end
                        r_eidx  <= r_eidx + ECNT_W'(1);
                        r_state <= w_last_edge ? S_PASS : S_EREAD;
                    end
                end
                S_PASS: begin
                    // a clean check pass or an unchanged pass ends the solve
                    if (r_check || !r_changed) begin
                        r_oidx  <= '0;
                        r_state <= S_ORD;
                    end else begin
                        if ((r_pass + VCNT_W'(1)) == r_nv) begin
                            r_check <= 1'b1;
                        end else begin
                            r_pass <= r_pass + VCNT_W'(1);
                        end
                        r_eidx    <= '0;
                        r_changed <= 1'b0;
                        r_state   <= (r_edge_total == '0) ? S_PASS : S_EREAD;
                    end
                end
                S_ORD: begin
                    r_state <= S_OSEND;
                end
                S_OSEND: begin
                    if (w_out_free) begin
                        if (w_out_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_oidx  <= r_oidx + VID_W'(1);
                            r_state <= S_ORD;
                        end
                    end
                end
                S_NEG: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // reached marks act as valid bits of the vertex store
    always_ff @(posedge i_clk) begin
        if (r_state == S_INIT) begin
            r_reached <= '0;
            if ({1'b0, r_src} < r_nv) begin
                r_reached[r_src] <= 1'b1;
            end
        end else if ((r_state == S_CMP) && w_better && !r_check) begin
            r_reached[w_edge.to] <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (((r_state == S_OSEND) || (r_state == S_NEG)) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OSEND) && w_out_free) begin
            r_out_vertex <= r_oidx;
            r_out_reach  <= r_reached[r_oidx];
            // unreached entries were never written this solve
            r_out_dist   <= r_reached[r_oidx] ? w_vent_a.path_dist : spr_pkg::UNREACHED_DIST;
            r_out_parent <= r_reached[r_oidx] ? w_vent_a.parent : r_oidx;
            r_out_status <= r_overflow ? spr_pkg::STS_DROPPED : spr_pkg::STS_OK;
            r_out_last   <= w_out_last;
        end else if ((r_state == S_NEG) && w_out_free) begin
            r_out_vertex <= w_edge.to;
            r_out_reach  <= 1'b0;
            r_out_dist   <= '0;
            r_out_parent <= w_edge.to;
            r_out_status <= spr_pkg::STS_NEG_CYC;
            r_out_last   <= 1'b1;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'd0, r_out_parent, r_out_reach, r_out_dist, r_out_vertex};
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tlast  = r_out_last;

    // edge count never passes the store depth
    a_edge_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edge_total <= ECNT_W'(spr_pkg::MAX_EDGES))
        else $error("edge count beyond store depth");

    // an improving relaxation outside the check pass marks the pass as changed
    a_change_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) && w_better && !r_check |=> r_changed)
        else $error("relaxation not recorded as change");

    // pass count stays below the vertex count while relaxation passes walk the edges
    a_pass_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EREAD) || (r_state == S_CMP) |-> (r_check || (r_pass < r_nv)))
        else $error("pass count reached vertex count");

    // a valid source is marked reached after init
    a_src_reached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) && ({1'b0, r_src} < r_nv) |=> r_reached[r_src])
        else $error("source not marked reached");

endmodule

// ===== src/spr_edge_mem.sv =====
`timescale 1ns / 1ps
// edge store: one write port, one registered read port
// depends on spr_pkg

module spr_edge_mem (
    input  logic                      i_clk,
    input  spr_pkg::t_edge_wr         i_wr,
    input  logic [spr_pkg::EIDX_W-1:0] i_rd_addr,
    output spr_pkg::t_edge            o_rd_data
);

    spr_pkg::t_edge r_mem [spr_pkg::MAX_EDGES];
    spr_pkg::t_edge r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/spr_vertex_mem.sv =====
`timescale 1ns / 1ps
// per-vertex distance and parent store: one write port, two registered read ports
// depends on spr_pkg

module spr_vertex_mem (
    input  logic                       i_clk,
    input  spr_pkg::t_vent_wr          i_wr,
    input  logic [spr_pkg::VID_W-1:0]  i_rd_addr_a,
    input  logic [spr_pkg::VID_W-1:0]  i_rd_addr_b,
    output spr_pkg::t_vent             o_rd_data_a,
    output spr_pkg::t_vent             o_rd_data_b
);

    spr_pkg::t_vent r_mem [spr_pkg::MAX_VERTICES];
    spr_pkg::t_vent r_rd_a;
    spr_pkg::t_vent r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ===== src/spr_relax_unit.sv =====
`timescale 1ns / 1ps
// shared relaxation unit: saturating add of tail distance and weight (registered),
// then compare against the head distance, an unreached head always better; depends on spr_pkg

module spr_relax_unit (
    input  logic                             i_clk,
    input  logic [spr_pkg::DIST_W-1:0]       i_dist_u,
    input  logic [spr_pkg::WEIGHT_BITS-1:0]  i_weight,
    input  logic [spr_pkg::DIST_W-1:0]       i_dist_v,
    input  logic                             i_v_reached,
    output logic [spr_pkg::DIST_W-1:0]       o_sum,
    output logic                             o_better
);

    logic [spr_pkg::DIST_W:0]   w_sum_wide;
    logic [spr_pkg::DIST_W-1:0] w_sum_sat;
    logic [spr_pkg::DIST_W-1:0] r_sum;

    assign w_sum_wide = {i_dist_u[spr_pkg::DIST_W-1], i_dist_u}
        + {{(spr_pkg::DIST_W + 1 - spr_pkg::WEIGHT_BITS){i_weight[spr_pkg::WEIGHT_BITS-1]}},
           i_weight};

    // clamp when the two top bits disagree
    always_comb begin
        if (w_sum_wide[spr_pkg::DIST_W] != w_sum_wide[spr_pkg::DIST_W-1]) begin
            w_sum_sat = w_sum_wide[spr_pkg::DIST_W] ? spr_pkg::DIST_MIN : spr_pkg::DIST_MAX;
        end else begin
            w_sum_sat = w_sum_wide[spr_pkg::DIST_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= w_sum_sat;
    end

    assign o_sum    = r_sum;
    assign o_better = !i_v_reached || ($signed(r_sum) < $signed(i_dist_v));

endmodule
